### sv/loa_pkg.sv
// shared constants, codes and types of the lane occupancy averager
`timescale 1ns / 1ps

package loa_pkg;

   // lane table
   localparam int LANE_SLOTS    = 8;
   localparam int LANES_DEFAULT = 8;
   localparam int CSR_IDX_W     = $clog2(LANE_SLOTS);

   // field widths
   localparam int DEV_W   = 16;
   localparam int CNT_W   = 16;
   localparam int TICK_W  = 32;
   localparam int VISIT_W = 16;
   localparam int AVG_W   = 31;
   localparam int OP_W    = 2;

   // serial bit counter covers one full tick word
   localparam int BIT_CNT_W = $clog2(TICK_W);

   // read saturation limits
   localparam logic [TICK_W-1:0] NARROW_LIMIT = 32'd65535;
   localparam logic [TICK_W-1:0] WIDE_LIMIT   = 32'd2147483647;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
   localparam logic [OP_W-1:0] OP_LEAVE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } seq_state_type;

endpackage

### sv/lane_occupancy_averager_unit.sv
// lane occupancy averager: lane table, bit-serial update pass and serial divider
`timescale 1ns / 1ps

// Keeps per-lane occupancy statistics for up to LANES lanes, each bound to a sensor id
// written through the csr port. A car-enter beat completes in the idle state. In a car-leave
// or tick beat the dwell, total and visit registers of the selected lanes are shift registers
// that a 32-step pass walks one bit per cycle through a one-bit adder per lane (the visit
// word only in its low VISIT_W steps). A read beat latches the highest matching lane, clears
// the matching lanes, and runs a restoring divider that yields one quotient bit per cycle,
// then waits for the result register to be free, saturates the average and loads it.
// req_stall is high while a beat is being worked on; a new beat may enter while a
// finished result still waits on rsp_stall.
module lane_occupancy_averager_unit
   import loa_pkg::*;
#(
   parameter int LANES = LANES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [DEV_W-1:0]     req_device_id,
   input  logic [CNT_W-1:0]     req_car_count,
   input  logic                 req_wide_read,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [AVG_W-1:0]     rsp_average_time,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DEV_W-1:0]     csr_wdata
);

   // sequencer
   seq_state_type          state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;

   // lane ids
   logic [DEV_W-1:0]       lane_id_ff [LANE_SLOTS];

   // lane statistics
   logic [LANES-1:0]       present_ff, present_in;
   logic [CNT_W-1:0]       entry_ff [LANES];
   logic [CNT_W-1:0]       entry_in [LANES];
   logic [TICK_W-1:0]      dwell_ff [LANES];
   logic [TICK_W-1:0]      dwell_in [LANES];
   logic [TICK_W-1:0]      total_ff [LANES];
   logic [TICK_W-1:0]      total_in [LANES];
   logic [VISIT_W-1:0]     visits_ff [LANES];
   logic [VISIT_W-1:0]     visits_in [LANES];

   // per-lane controls of the serial pass
   logic [LANES-1:0]       add_ff, add_in;
   logic [LANES-1:0]       inc_ff, inc_in;
   logic [LANES-1:0]       clr_ff, clr_in;
   logic [LANES-1:0]       carry_ff, carry_in;
   logic [LANES-1:0]       vcarry_ff, vcarry_in;

   // divider
   logic [TICK_W-1:0]      quo_ff, quo_in;
   logic [VISIT_W-1:0]     rem_ff, rem_in;
   logic [VISIT_W-1:0]     divisor_ff, divisor_in;
   logic                   nonzero_ff, nonzero_in;
   logic                   wide_ff, wide_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]       avg_ff, avg_in;

   // helpers
   logic [LANES-1:0]       match;
   logic                   accept;
   logic [TICK_W-1:0]      sel_total;
   logic [VISIT_W-1:0]     sel_visits;
   logic [VISIT_W:0]       trial;
   logic [VISIT_W:0]       diff;
   logic                   qbit;
   logic [TICK_W-1:0]      limit;
   logic [TICK_W-1:0]      avg_full;
   logic                   last_bit;
   logic                   out_free;

   assign req_stall        = (state_ff != ST_IDLE);
   assign accept           = req_valid && !req_stall;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average_time = avg_ff;
   assign last_bit         = (bit_cnt_ff == BIT_CNT_W'(TICK_W - 1));
   assign out_free         = !rsp_valid_ff || !rsp_stall;

   // lane match and read selection, highest matching lane wins
   always_comb begin
      sel_total  = '0;
      sel_visits = '0;
      for (int l = 0; l < LANES; l++) begin
         match[l] = (lane_id_ff[l] == req_device_id);
         if (match[l]) begin
            sel_total  = total_ff[l];
            sel_visits = visits_ff[l];
         end
      end
   end

   // divider step and saturation
   always_comb begin
      trial    = {rem_ff, quo_ff[TICK_W-1]};
      diff     = trial - {1'b0, divisor_ff};
      qbit     = (trial >= {1'b0, divisor_ff});
      limit    = wide_ff ? WIDE_LIMIT : NARROW_LIMIT;
      avg_full = '0;
      if (nonzero_ff) begin
         avg_full = (quo_ff >= limit) ? limit : quo_ff;
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      present_in   = present_ff;
      entry_in     = entry_ff;
      dwell_in     = dwell_ff;
      total_in     = total_ff;
      visits_in    = visits_ff;
      add_in       = add_ff;
      inc_in       = inc_ff;
      clr_in       = clr_ff;
      carry_in     = carry_ff;
      vcarry_in    = vcarry_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      nonzero_in   = nonzero_ff;
      wide_in      = wide_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff;

      // result beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ENTER: begin
                     for (int l = 0; l < LANES; l++) begin
                        if (match[l]) begin
                           entry_in[l]   = req_car_count;
                           present_in[l] = 1'b1;
                           dwell_in[l]   = '0;
                        end
                     end
                  end
                  OP_LEAVE: begin
                     for (int l = 0; l < LANES; l++) begin
                        add_in[l]    = match[l] && (|dwell_ff[l])
                                       && (req_car_count == entry_ff[l]);
                        clr_in[l]    = match[l];
                        inc_in[l]    = 1'b0;
                        carry_in[l]  = 1'b0;
                        vcarry_in[l] = 1'b1;
                        if (match[l]) begin
                           present_in[l] = 1'b0;
                        end
                     end
                     bit_cnt_in = '0;
                     state_in   = ST_SCAN;
                  end
                  OP_TICK: begin
                     for (int l = 0; l < LANES; l++) begin
                        add_in[l]    = 1'b0;
                        clr_in[l]    = 1'b0;
                        inc_in[l]    = present_ff[l] && !(&dwell_ff[l]);
                        carry_in[l]  = 1'b1;
                        vcarry_in[l] = 1'b0;
                     end
                     bit_cnt_in = '0;
                     state_in   = ST_SCAN;
                  end
                  OP_READ: begin
                     quo_in     = sel_total;
                     divisor_in = sel_visits;
                     nonzero_in = |sel_visits;
                     wide_in    = req_wide_read;
                     rem_in     = '0;
                     for (int l = 0; l < LANES; l++) begin
                        if (match[l]) begin
                           total_in[l]  = '0;
                           visits_in[l] = '0;
                        end
                     end
                     bit_cnt_in = '0;
                     state_in   = ST_DIV;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // one bit of each selected lane's dwell, total and visit words per cycle
         ST_SCAN: begin
            for (int l = 0; l < LANES; l++) begin
               if (add_ff[l]) begin
                  total_in[l] = {total_ff[l][0] ^ dwell_ff[l][0] ^ carry_ff[l],
                                 total_ff[l][TICK_W-1:1]};
                  carry_in[l] = (total_ff[l][0] & dwell_ff[l][0])
                              | (total_ff[l][0] & carry_ff[l])
                              | (dwell_ff[l][0] & carry_ff[l]);
                  if (bit_cnt_ff < BIT_CNT_W'(VISIT_W)) begin
                     visits_in[l] = {visits_ff[l][0] ^ vcarry_ff[l],
                                     visits_ff[l][VISIT_W-1:1]};
                     vcarry_in[l] = visits_ff[l][0] & vcarry_ff[l];
                  end
               end
               if (inc_ff[l]) begin
                  dwell_in[l] = {dwell_ff[l][0] ^ carry_ff[l], dwell_ff[l][TICK_W-1:1]};
                  carry_in[l] = dwell_ff[l][0] & carry_ff[l];
               end else if (clr_ff[l]) begin
                  dwell_in[l] = {1'b0, dwell_ff[l][TICK_W-1:1]};
               end
            end
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (last_bit) begin
               state_in = ST_IDLE;
            end
         end

         // restoring division, one quotient bit per cycle
         ST_DIV: begin
            rem_in     = qbit ? diff[VISIT_W-1:0] : trial[VISIT_W-1:0];
            quo_in     = {quo_ff[TICK_W-2:0], qbit};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (last_bit) begin
               state_in = ST_DONE;
            end
         end

         // hand the average to the result register
         ST_DONE: begin
            if (out_free) begin
               avg_in       = avg_full[AVG_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= '0;
         add_ff       <= '0;
         inc_ff       <= '0;
         clr_ff       <= '0;
         carry_ff     <= '0;
         vcarry_ff    <= '0;
         for (int l = 0; l < LANE_SLOTS; l++) begin
            lane_id_ff[l] <= '0;
         end
         for (int l = 0; l < LANES; l++) begin
            entry_ff[l]  <= '0;
            dwell_ff[l]  <= '0;
            total_ff[l]  <= '0;
            visits_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         add_ff       <= add_in;
         inc_ff       <= inc_in;
         clr_ff       <= clr_in;
         carry_ff     <= carry_in;
         vcarry_ff    <= vcarry_in;
         entry_ff     <= entry_in;
         dwell_ff     <= dwell_in;
         total_ff     <= total_in;
         visits_ff    <= visits_in;
         if (csr_valid && csr_ready) begin
            lane_id_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // divider and result payload
   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      nonzero_ff <= nonzero_in;
      wide_ff    <= wide_in;
      avg_ff     <= avg_in;
   end

endmodule
